/* rtl/core/polygon_zone_clearance_check_top_defines.svh */
// Assertion macros for the polygon zone clearance check, used by the port-level checker.
`ifndef POLYGON_ZONE_CLEARANCE_CHECK_TOP_DEFINES_SVH
`define POLYGON_ZONE_CLEARANCE_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PZC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pzc: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define PZC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pzc: next-cycle check failed");

`endif

/* rtl/core/pzc_pkg.sv */
// Package: widths, codes, payload and internal types of the zone clearance check.
`default_nettype none
package pzc_pkg;

  localparam int COORD_BITS    = 24;
  localparam int RAD_BITS      = COORD_BITS - 1;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * DIFF_BITS;
  localparam int SUM_BITS      = PROD_BITS + 1;
  localparam int MAG_BITS      = PROD_BITS;
  localparam int HALF_BITS     = MAG_BITS / 2;
  localparam int R2_BITS       = 2 * RAD_BITS;
  localparam int WIDE_BITS     = 2 * MAG_BITS;
  localparam int MAX_VERTICES  = 16;
  localparam int MAX_OBSTACLES = 16;
  localparam int MIN_VERTICES  = 3;
  localparam int RING_DEPTH    = 16;
  localparam int STEP_BITS     = $clog2(RING_DEPTH);
  localparam int SLOT_BITS     = 4;
  localparam int COUNT_BITS    = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int EDGE_STAGES   = 6;

  localparam logic [1:0] OP_LOAD_VERTEX   = 2'd0;
  localparam logic [1:0] OP_LOAD_OBSTACLE = 2'd1;
  localparam logic [1:0] OP_CHECK         = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BOUNDARY_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CYLINDER_COUNT = 2'd1;

  typedef enum logic [2:0] {
    VERDICT_CLEAR       = 3'd0,
    VERDICT_ON_EDGE     = 3'd1,
    VERDICT_NEAR_EDGE   = 3'd2,
    VERDICT_OUTSIDE     = 3'd3,
    VERDICT_IN_CYLINDER = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [1:0]                   op;
    logic [SLOT_BITS-1:0]         slot;
    logic signed [COORD_BITS-1:0] north;
    logic signed [COORD_BITS-1:0] east;
    logic signed [COORD_BITS-1:0] down;
    logic [RAD_BITS-1:0]          radius;
    logic [RAD_BITS-1:0]          height;
  } item_t;

  typedef struct packed {
    logic       clear;
    logic [2:0] verdict;
  } result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] north;
    logic signed [COORD_BITS-1:0] east;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] north;
    logic signed [COORD_BITS-1:0] east;
    logic [RAD_BITS-1:0]          radius;
    logic [RAD_BITS-1:0]          height;
  } obstacle_t;

  typedef struct packed {
    vertex_t   vtx;
    obstacle_t obs;
  } entry_t;

  typedef struct packed {
    logic    valid;
    vertex_t a;
    vertex_t b;
  } edge_in_t;

  typedef struct packed {
    logic     valid;
    logic     toggle;
    verdict_t code;
  } edge_res_t;

  typedef struct packed {
    logic      valid;
    obstacle_t obs;
  } obs_in_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } obs_res_t;

endpackage
`default_nettype wire

/* rtl/core/pzc_cell.sv */
// One ring cell: holds a vertex and an obstacle entry, rotates to its neighbor.
`default_nettype none
module pzc_cell (
  input  wire logic                      clk,
  input  wire logic                      shift,
  input  wire logic                      load_vertex,
  input  wire logic                      load_obstacle,
  input  wire pzc_pkg::item_t            item,
  input  wire pzc_pkg::entry_t           shift_in,
  output pzc_pkg::entry_t                entry
);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= shift_in;
    end else begin
      if (load_vertex) begin
        entry.vtx.north <= item.north;
        entry.vtx.east  <= item.east;
      end
      if (load_obstacle) begin
        entry.obs.north  <= item.north;
        entry.obs.east   <= item.east;
        entry.obs.radius <= item.radius;
        entry.obs.height <= item.height;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pzc_edge_unit.sv */
// Six-stage edge pipeline: crossing test and exact segment clearance test.
`default_nettype none
module pzc_edge_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire pzc_pkg::edge_in_t                     edge_in,
  input  wire logic signed [pzc_pkg::COORD_BITS-1:0] pn,
  input  wire logic signed [pzc_pkg::COORD_BITS-1:0] pe,
  input  wire logic [pzc_pkg::R2_BITS-1:0]           r2,
  output pzc_pkg::edge_res_t                         res
);

  logic [pzc_pkg::EDGE_STAGES-2:0] vld;

  // stage 1
  logic signed [pzc_pkg::DIFF_BITS-1:0] dn, de, qn, qe, wn, we;
  logic in_range1, de_neg1;
  // stage 2
  logic signed [pzc_pkg::PROD_BITS-1:0] qn_de, dn_qe, dn2, de2, qn_dn, qe_de, qn2, qe2, wn2, we2;
  logic in_range2, de_neg2;
  // stage 3
  logic signed [pzc_pkg::SUM_BITS-1:0] cross_pos, cross_neg, len2, t, da2, db2;
  logic in_range3, de_neg3;
  // stage 4
  logic cross_fail4, toggle4, near_a4, near_b4, t_le0_4, t_ge4;
  logic [pzc_pkg::PROD_BITS-1:0] p_hh, p_hl, p_ll, q_hh, q_hl, q_lh, q_ll;
  // stage 5
  logic cross_fail5, toggle5, near_a5, near_b5, t_le0_5, t_ge5;
  logic [pzc_pkg::WIDE_BITS-1:0] csq, rl;

  logic signed [pzc_pkg::COORD_BITS-1:0] elo, ehi;
  logic signed [pzc_pkg::SUM_BITS-1:0]   r2_s;
  logic [pzc_pkg::MAG_BITS-1:0]          mag, l_mag;
  logic [pzc_pkg::HALF_BITS-1:0]         c_hi, c_lo, l_hi, l_lo, r_lo;
  logic [pzc_pkg::R2_BITS-pzc_pkg::HALF_BITS-1:0] r_hi;
  logic near_mid, near;

  always_comb begin
    elo   = (edge_in.a.east < edge_in.b.east) ? edge_in.a.east : edge_in.b.east;
    ehi   = (edge_in.a.east < edge_in.b.east) ? edge_in.b.east : edge_in.a.east;
    r2_s  = $signed(pzc_pkg::SUM_BITS'(r2));
    mag   = cross_pos[pzc_pkg::SUM_BITS-1] ? cross_neg[pzc_pkg::MAG_BITS-1:0]
                                           : cross_pos[pzc_pkg::MAG_BITS-1:0];
    l_mag = len2[pzc_pkg::MAG_BITS-1:0];
    c_hi  = mag[pzc_pkg::MAG_BITS-1:pzc_pkg::HALF_BITS];
    c_lo  = mag[pzc_pkg::HALF_BITS-1:0];
    l_hi  = l_mag[pzc_pkg::MAG_BITS-1:pzc_pkg::HALF_BITS];
    l_lo  = l_mag[pzc_pkg::HALF_BITS-1:0];
    r_hi  = r2[pzc_pkg::R2_BITS-1:pzc_pkg::HALF_BITS];
    r_lo  = r2[pzc_pkg::HALF_BITS-1:0];
    // Inside the segment span, d^2 < r^2 is cross^2 < r^2 * len^2 (Lagrange identity).
    near_mid = csq < rl;
    near = t_le0_5 ? near_a5 : (t_ge5 ? near_b5 : near_mid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[pzc_pkg::EDGE_STAGES-3:0], edge_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    dn <= pzc_pkg::DIFF_BITS'(edge_in.b.north) - pzc_pkg::DIFF_BITS'(edge_in.a.north);
    de <= pzc_pkg::DIFF_BITS'(edge_in.b.east)  - pzc_pkg::DIFF_BITS'(edge_in.a.east);
    qn <= pzc_pkg::DIFF_BITS'(pn) - pzc_pkg::DIFF_BITS'(edge_in.a.north);
    qe <= pzc_pkg::DIFF_BITS'(pe) - pzc_pkg::DIFF_BITS'(edge_in.a.east);
    wn <= pzc_pkg::DIFF_BITS'(pn) - pzc_pkg::DIFF_BITS'(edge_in.b.north);
    we <= pzc_pkg::DIFF_BITS'(pe) - pzc_pkg::DIFF_BITS'(edge_in.b.east);
    in_range1 <= (pe >= elo) && (pe < ehi);
    de_neg1   <= edge_in.b.east < edge_in.a.east;

    qn_de <= qn * de;
    dn_qe <= dn * qe;
    dn2   <= dn * dn;
    de2   <= de * de;
    qn_dn <= qn * dn;
    qe_de <= qe * de;
    qn2   <= qn * qn;
    qe2   <= qe * qe;
    wn2   <= wn * wn;
    we2   <= we * we;
    in_range2 <= in_range1;
    de_neg2   <= de_neg1;

    cross_pos <= pzc_pkg::SUM_BITS'(qn_de) - pzc_pkg::SUM_BITS'(dn_qe);
    cross_neg <= pzc_pkg::SUM_BITS'(dn_qe) - pzc_pkg::SUM_BITS'(qn_de);
    len2      <= pzc_pkg::SUM_BITS'(dn2) + pzc_pkg::SUM_BITS'(de2);
    t         <= pzc_pkg::SUM_BITS'(qn_dn) + pzc_pkg::SUM_BITS'(qe_de);
    da2       <= pzc_pkg::SUM_BITS'(qn2) + pzc_pkg::SUM_BITS'(qe2);
    db2       <= pzc_pkg::SUM_BITS'(wn2) + pzc_pkg::SUM_BITS'(we2);
    in_range3 <= in_range2;
    de_neg3   <= de_neg2;

    // sign flips with a westward edge; zero cross means the point is on the line
    cross_fail4 <= in_range3 && (cross_pos == '0);
    toggle4     <= in_range3 && (cross_pos != '0) &&
                   ((!cross_pos[pzc_pkg::SUM_BITS-1]) ^ de_neg3);
    near_a4 <= da2 < r2_s;
    near_b4 <= db2 < r2_s;
    t_le0_4 <= t[pzc_pkg::SUM_BITS-1] || (t == '0);
    t_ge4   <= t >= len2;
    p_hh <= pzc_pkg::PROD_BITS'(c_hi * c_hi);
    p_hl <= pzc_pkg::PROD_BITS'(c_hi * c_lo);
    p_ll <= pzc_pkg::PROD_BITS'(c_lo * c_lo);
    q_hh <= pzc_pkg::PROD_BITS'(r_hi * l_hi);
    q_hl <= pzc_pkg::PROD_BITS'(r_hi * l_lo);
    q_lh <= pzc_pkg::PROD_BITS'(r_lo * l_hi);
    q_ll <= pzc_pkg::PROD_BITS'(r_lo * l_lo);

    cross_fail5 <= cross_fail4;
    toggle5     <= toggle4;
    near_a5     <= near_a4;
    near_b5     <= near_b4;
    t_le0_5     <= t_le0_4;
    t_ge5       <= t_ge4;
    csq <= (pzc_pkg::WIDE_BITS'(p_hh) << (2 * pzc_pkg::HALF_BITS)) +
           (pzc_pkg::WIDE_BITS'(p_hl) << (pzc_pkg::HALF_BITS + 1)) +
           pzc_pkg::WIDE_BITS'(p_ll);
    rl  <= (pzc_pkg::WIDE_BITS'(q_hh) << (2 * pzc_pkg::HALF_BITS)) +
           (pzc_pkg::WIDE_BITS'(q_hl) << pzc_pkg::HALF_BITS) +
           (pzc_pkg::WIDE_BITS'(q_lh) << pzc_pkg::HALF_BITS) +
           pzc_pkg::WIDE_BITS'(q_ll);

    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= vld[pzc_pkg::EDGE_STAGES-2];
    end
    res.toggle <= toggle5;
    if (cross_fail5) begin
      res.code <= pzc_pkg::VERDICT_ON_EDGE;
    end else if (near) begin
      res.code <= pzc_pkg::VERDICT_NEAR_EDGE;
    end else begin
      res.code <= pzc_pkg::VERDICT_CLEAR;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pzc_obstacle_unit.sv */
// Three-stage cylinder overlap pipeline: horizontal distance and altitude.
`default_nettype none
module pzc_obstacle_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire pzc_pkg::obs_in_t                      obs_in,
  input  wire logic signed [pzc_pkg::COORD_BITS-1:0] pn,
  input  wire logic signed [pzc_pkg::COORD_BITS-1:0] pe,
  input  wire logic signed [pzc_pkg::COORD_BITS-1:0] pd,
  input  wire logic [pzc_pkg::RAD_BITS-1:0]          r,
  output pzc_pkg::obs_res_t                          res
);

  logic [1:0] vld;
  logic signed [pzc_pkg::DIFF_BITS-1:0] dn, de, neg_pd, lim;
  logic [pzc_pkg::COORD_BITS-1:0]       rr;
  logic                                 h_ok1, h_ok2;
  logic signed [pzc_pkg::PROD_BITS-1:0] dn2, de2;
  logic [2*pzc_pkg::COORD_BITS-1:0]     rr2;

  always_comb begin
    neg_pd = -pzc_pkg::DIFF_BITS'(pd);
    lim    = $signed(pzc_pkg::DIFF_BITS'(obs_in.obs.height) + pzc_pkg::DIFF_BITS'(r));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[0], obs_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    dn    <= pzc_pkg::DIFF_BITS'(pn) - pzc_pkg::DIFF_BITS'(obs_in.obs.north);
    de    <= pzc_pkg::DIFF_BITS'(pe) - pzc_pkg::DIFF_BITS'(obs_in.obs.east);
    rr    <= pzc_pkg::COORD_BITS'(obs_in.obs.radius) + pzc_pkg::COORD_BITS'(r);
    h_ok1 <= neg_pd < lim;

    dn2   <= dn * dn;
    de2   <= de * de;
    rr2   <= rr * rr;
    h_ok2 <= h_ok1;

    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= vld[1];
    end
    res.hit <= h_ok2 && ((pzc_pkg::SUM_BITS'(dn2) + pzc_pkg::SUM_BITS'(de2)) <
                         $signed(pzc_pkg::SUM_BITS'(rr2)));
  end

endmodule
`default_nettype wire

/* rtl/core/polygon_zone_clearance_check_top.sv */
// Top level: vertex/obstacle ring, edge and obstacle pipelines, control and result register.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------------------------
//  item     | in        | item_valid / item_stall      | pzc_pkg::item_t
//  result   | out       | result_valid / result_stall  | pzc_pkg::result_t
//  cfg      | in        | cfg_write (no wait)          | cfg_index, cfg_data
//
// Load items are taken while idle and start no check. For a check item the ring of 16 cells
// rotates once past the edge and obstacle pipelines (SCAN), the 6-stage edge pipeline drains
// (DRAIN), and FINISH forms the verdict and posts the result.
// Reset (rst, synchronous) clears control, sets boundary_count to 12, cylinder_count to 0.
// item_stall is high while a check runs; a waiting result does not block the next item
// until the following check is ready to post its own result.
`default_nettype none
module polygon_zone_clearance_check_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire pzc_pkg::item_t                      item,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output pzc_pkg::result_t                         result,
  input  wire logic                                cfg_write,
  input  wire logic [pzc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [pzc_pkg::COUNT_BITS-1:0]      cfg_data
);

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, FINISH} state_t;

  state_t                               state;
  logic [pzc_pkg::STEP_BITS-1:0]        step;
  logic [pzc_pkg::COUNT_BITS-1:0]       boundary_count, cylinder_count;
  logic [pzc_pkg::COUNT_BITS-1:0]       edge_count, obs_count;
  logic [pzc_pkg::COUNT_BITS-1:0]       edge_count_next, obs_count_next;
  logic signed [pzc_pkg::COORD_BITS-1:0] pn, pe, pd;
  logic [pzc_pkg::RAD_BITS-1:0]         r;
  logic [pzc_pkg::R2_BITS-1:0]          r2;
  pzc_pkg::vertex_t                     v0;
  pzc_pkg::verdict_t                    fail_code, final_code;
  logic                                 odd, hit;

  logic                                 item_accept, result_take, scanning, last_edge;
  pzc_pkg::entry_t                      ring [pzc_pkg::RING_DEPTH];
  pzc_pkg::edge_in_t                    edge_in;
  pzc_pkg::edge_res_t                   edge_res;
  pzc_pkg::obs_in_t                     obs_in;
  pzc_pkg::obs_res_t                    obs_res;

  assign item_stall  = (state != IDLE);
  assign item_accept = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;
  assign scanning    = (state == SCAN);
  assign last_edge   = pzc_pkg::COUNT_BITS'(step) == edge_count - 1'b1;

  // Clamp the counts into their legal ranges when a check starts.
  always_comb begin
    if (boundary_count < pzc_pkg::COUNT_BITS'(pzc_pkg::MIN_VERTICES)) begin
      edge_count_next = pzc_pkg::COUNT_BITS'(pzc_pkg::MIN_VERTICES);
    end else if (boundary_count > pzc_pkg::COUNT_BITS'(pzc_pkg::MAX_VERTICES)) begin
      edge_count_next = pzc_pkg::COUNT_BITS'(pzc_pkg::MAX_VERTICES);
    end else begin
      edge_count_next = boundary_count;
    end
    if (cylinder_count > pzc_pkg::COUNT_BITS'(pzc_pkg::MAX_OBSTACLES)) begin
      obs_count_next = pzc_pkg::COUNT_BITS'(pzc_pkg::MAX_OBSTACLES);
    end else begin
      obs_count_next = cylinder_count;
    end
  end

  // Ring of cells: at scan step k cell 0 holds entry k and cell 1 holds entry k+1.
  for (genvar i = 0; i < pzc_pkg::RING_DEPTH; i++) begin : g_ring
    pzc_cell u_cell (
      .clk           (clk),
      .shift         (scanning),
      .load_vertex   (item_accept && item.op == pzc_pkg::OP_LOAD_VERTEX &&
                      item.slot == pzc_pkg::SLOT_BITS'(i)),
      .load_obstacle (item_accept && item.op == pzc_pkg::OP_LOAD_OBSTACLE &&
                      item.slot == pzc_pkg::SLOT_BITS'(i)),
      .item          (item),
      .shift_in      (ring[(i + 1) % pzc_pkg::RING_DEPTH]),
      .entry         (ring[i])
    );
  end

  // Feed one edge and one obstacle per scan step; the last edge closes to vertex 0.
  always_comb begin
    edge_in.valid = scanning && (pzc_pkg::COUNT_BITS'(step) < edge_count);
    edge_in.a     = ring[0].vtx;
    edge_in.b     = last_edge ? v0 : ring[1].vtx;
    obs_in.valid  = scanning && (pzc_pkg::COUNT_BITS'(step) < obs_count);
    obs_in.obs    = ring[0].obs;
  end

  pzc_edge_unit u_edge (
    .clk     (clk),
    .rst     (rst),
    .edge_in (edge_in),
    .pn      (pn),
    .pe      (pe),
    .r2      (r2),
    .res     (edge_res)
  );

  pzc_obstacle_unit u_obstacle (
    .clk    (clk),
    .rst    (rst),
    .obs_in (obs_in),
    .pn     (pn),
    .pe     (pe),
    .pd     (pd),
    .r      (r),
    .res    (obs_res)
  );

  // First failing edge decides; then an even crossing count; then any cylinder.
  always_comb begin
    if (fail_code != pzc_pkg::VERDICT_CLEAR) begin
      final_code = fail_code;
    end else if (!odd) begin
      final_code = pzc_pkg::VERDICT_OUTSIDE;
    end else if (hit) begin
      final_code = pzc_pkg::VERDICT_IN_CYLINDER;
    end else begin
      final_code = pzc_pkg::VERDICT_CLEAR;
    end
  end

  // Query point and radius: hold for the whole check.
  always_ff @(posedge clk) begin
    if (item_accept && item.op == pzc_pkg::OP_CHECK) begin
      pn <= item.north;
      pe <= item.east;
      pd <= item.down;
      r  <= item.radius;
      edge_count <= edge_count_next;
      obs_count  <= obs_count_next;
    end
    r2 <= r * r;
    if (scanning && step == '0) begin
      v0 <= ring[0].vtx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      step           <= '0;
      boundary_count <= pzc_pkg::COUNT_BITS'(12);
      cylinder_count <= '0;
      fail_code      <= pzc_pkg::VERDICT_CLEAR;
      odd            <= 1'b0;
      hit            <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pzc_pkg::CFG_BOUNDARY_COUNT: boundary_count <= cfg_data;
          pzc_pkg::CFG_CYLINDER_COUNT: cylinder_count <= cfg_data;
          default: ;
        endcase
      end

      // Collect pipeline results in edge order.
      if (edge_res.valid) begin
        if (fail_code == pzc_pkg::VERDICT_CLEAR) begin
          fail_code <= edge_res.code;
        end
        if (edge_res.toggle) begin
          odd <= !odd;
        end
      end
      if (obs_res.valid && obs_res.hit) begin
        hit <= 1'b1;
      end

      // In FINISH a transfer out always coincides with a new post below.
      if (result_take && state != FINISH) begin
        result_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (item_accept && item.op == pzc_pkg::OP_CHECK) begin
            state     <= SCAN;
            step      <= '0;
            fail_code <= pzc_pkg::VERDICT_CLEAR;
            odd       <= 1'b0;
            hit       <= 1'b0;
          end
        end
        SCAN: begin
          step <= step + 1'b1;
          if (step == pzc_pkg::STEP_BITS'(pzc_pkg::RING_DEPTH - 1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          step <= step + 1'b1;
          if (step == pzc_pkg::STEP_BITS'(pzc_pkg::EDGE_STAGES - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          // Post once the result register is free or being emptied this cycle.
          if (!result_valid || !result_stall) begin
            result_valid   <= 1'b1;
            result.verdict <= final_code;
            result.clear   <= (final_code == pzc_pkg::VERDICT_CLEAR);
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pzc_checker.sv */
// Port-level checker for the zone clearance check, bound to the top level.
`default_nettype none
`include "polygon_zone_clearance_check_top_defines.svh"
module pzc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire pzc_pkg::item_t   item,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire pzc_pkg::result_t result
);

  `PZC_ASSERT_NOW(a_clear_matches, clk, rst, result_valid, (result.clear == (result.verdict == pzc_pkg::VERDICT_CLEAR)))
  `PZC_ASSERT_NOW(a_verdict_known, clk, rst, result_valid, (result.verdict <= pzc_pkg::VERDICT_IN_CYLINDER))
  `PZC_ASSERT_NEXT(a_busy_after_check, clk, rst, (item_valid && !item_stall && item.op == pzc_pkg::OP_CHECK), item_stall)
  `PZC_ASSERT_NEXT(a_result_holds, clk, rst, (result_valid && result_stall), (result_valid && $stable(result)))

endmodule

bind polygon_zone_clearance_check_top pzc_checker u_pzc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire

/* dv/polygon_zone_clearance_check_checker.sv */
// Checker: watches the item, config and result channels, predicts verdicts and compares them.
module polygon_zone_clearance_check_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  pzc_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  pzc_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [pzc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [pzc_pkg::COUNT_BITS-1:0]   cfg_data,
  output int               failures,
  output int               pending
);

  typedef logic signed [127:0] wide_t;

  logic signed [pzc_pkg::COORD_BITS-1:0] vtx_north [pzc_pkg::MAX_VERTICES];
  logic signed [pzc_pkg::COORD_BITS-1:0] vtx_east  [pzc_pkg::MAX_VERTICES];
  pzc_pkg::obstacle_t                    obstacles [pzc_pkg::MAX_OBSTACLES];
  logic [pzc_pkg::COUNT_BITS-1:0]        boundary_count;
  logic [pzc_pkg::COUNT_BITS-1:0]        cylinder_count;
  pzc_pkg::result_t                      verdict_queue [$];

  function automatic int sign_of(wide_t v);
    return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
  endfunction

  function automatic pzc_pkg::verdict_t zone_verdict(wide_t pn, wide_t pe, wide_t pd, wide_t r);
    int    n, m, s, j;
    logic  odd, near;
    wide_t r2, an, ae, bn, be, dn, de, qn, qe, elo, ehi, len2, t, rr, d2;
    n = (boundary_count < pzc_pkg::MIN_VERTICES) ? pzc_pkg::MIN_VERTICES :
        (boundary_count > pzc_pkg::MAX_VERTICES) ? pzc_pkg::MAX_VERTICES : int'(boundary_count);
    m = (cylinder_count > pzc_pkg::MAX_OBSTACLES) ? pzc_pkg::MAX_OBSTACLES
                                                  : int'(cylinder_count);
    odd = 1'b0;
    r2 = r * r;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      an = vtx_north[i]; ae = vtx_east[i];
      bn = vtx_north[j]; be = vtx_east[j];
      dn = bn - an; de = be - ae; qn = pn - an; qe = pe - ae;
      elo = (ae < be) ? ae : be;
      ehi = (ae < be) ? be : ae;
      if (pe >= elo && pe < ehi) begin
        s = sign_of(qn * de - dn * qe);
        if (de < 0) s = -s;
        if (s > 0) odd = !odd;
        else if (s == 0) return pzc_pkg::VERDICT_ON_EDGE;
      end
      len2 = dn * dn + de * de;
      t = qn * dn + qe * de;
      if (t <= 0) near = (qn * qn + qe * qe) < r2;
      else if (t >= len2) near = ((pn - bn) * (pn - bn) + (pe - be) * (pe - be)) < r2;
      else near = (qn * qn + qe * qe) * len2 < r2 * len2 + t * t;
      if (near) return pzc_pkg::VERDICT_NEAR_EDGE;
    end
    if (!odd) return pzc_pkg::VERDICT_OUTSIDE;
    for (int i = 0; i < m; i++) begin
      rr = wide_t'(obstacles[i].radius) + r;
      d2 = (pn - wide_t'(obstacles[i].north)) * (pn - wide_t'(obstacles[i].north)) +
           (pe - wide_t'(obstacles[i].east)) * (pe - wide_t'(obstacles[i].east));
      if (d2 < rr * rr && -pd < wide_t'(obstacles[i].height) + r)
        return pzc_pkg::VERDICT_IN_CYLINDER;
    end
    return pzc_pkg::VERDICT_CLEAR;
  endfunction

  assign pending = verdict_queue.size();

  always @(posedge clk) begin
    pzc_pkg::result_t  want, fresh;
    pzc_pkg::verdict_t v;
    if (rst) begin
      boundary_count <= 5'd12;
      cylinder_count <= 5'd0;
      failures <= 0;
      verdict_queue.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == pzc_pkg::CFG_BOUNDARY_COUNT) boundary_count <= cfg_data;
        else if (cfg_index == pzc_pkg::CFG_CYLINDER_COUNT) cylinder_count <= cfg_data;
      end
      if (item_valid && !item_stall) begin
        case (item.op)
          pzc_pkg::OP_LOAD_VERTEX: begin
            vtx_north[item.slot] = item.north;
            vtx_east[item.slot]  = item.east;
          end
          pzc_pkg::OP_LOAD_OBSTACLE:
            obstacles[item.slot] = '{item.north, item.east, item.radius, item.height};
          pzc_pkg::OP_CHECK: begin
            v = zone_verdict(wide_t'(item.north), wide_t'(item.east), wide_t'(item.down),
                             wide_t'({1'b0, item.radius}));
            fresh.clear   = (v == pzc_pkg::VERDICT_CLEAR);
            fresh.verdict = v;
            verdict_queue = {verdict_queue, fresh};
          end
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (verdict_queue.size() == 0) begin
          if (failures < 10) $display("unexpected result clear=%0d verdict=%0d",
                                      result.clear, result.verdict);
          failures <= failures + 1;
        end else begin
          want = verdict_queue.pop_front();
          if (want !== result) begin
            if (failures < 10)
              $display("verdict mismatch: expected clear=%0d verdict=%0d, got clear=%0d verdict=%0d",
                       want.clear, want.verdict, result.clear, result.verdict);
            failures <= failures + 1;
          end
        end
      end
    end
  end
endmodule

/* dv/polygon_zone_clearance_check_top_tb.sv */
// Testbench top: drives zone loads, checks and config writes, and reports the verdict.
module polygon_zone_clearance_check_top_tb;

  localparam int DRAIN_CYCLES = 40;
  // Codes outside the defined sets, used to check that they are ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [pzc_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
  localparam logic [pzc_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  pzc_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  pzc_pkg::result_t result;
  logic cfg_write = 1'b0;
  logic [pzc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [pzc_pkg::COUNT_BITS-1:0] cfg_data = '0;
  int failures, pending;
  logic quiet = 1'b0;
  int stall_hold = 0;

  // Current polygon, kept here so queries can aim at its edges and vertices.
  int poly_north [pzc_pkg::MAX_VERTICES];
  int poly_east  [pzc_pkg::MAX_VERTICES];
  int poly_sides, center_n, center_e, span;

  polygon_zone_clearance_check_top DUT (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .cfg_write, .cfg_index, .cfg_data
  );

  polygon_zone_clearance_check_checker checker_i (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .cfg_write, .cfg_index, .cfg_data, .failures, .pending
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result-side backpressure: mostly open, short stalls, now and then a long one.
  always @(posedge clk) begin
    int roll;
    if (rst) begin
      result_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (quiet) begin
      result_stall <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      result_stall <= (roll >= 65);
      stall_hold <= (roll >= 95) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  function automatic int gap_len();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one item and hold it until the transfer; drop valid only across a gap.
  task automatic send(pzc_pkg::item_t x);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // Pause the sender until every result is back and the block has gone quiet.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [pzc_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [pzc_pkg::COUNT_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic send_op(logic [1:0] op, int slot, int n, int e, int d, int r, int h);
    pzc_pkg::item_t x;
    x = '0;
    x.op = op;
    x.slot = slot[pzc_pkg::SLOT_BITS-1:0];
    x.north = n[pzc_pkg::COORD_BITS-1:0];
    x.east = e[pzc_pkg::COORD_BITS-1:0];
    x.down = d[pzc_pkg::COORD_BITS-1:0];
    x.radius = r[pzc_pkg::RAD_BITS-1:0];
    x.height = h[pzc_pkg::RAD_BITS-1:0];
    send(x);
  endtask

  task automatic load_vertex(int slot, int n, int e);
    poly_north[slot] = n;
    poly_east[slot] = e;
    send_op(pzc_pkg::OP_LOAD_VERTEX, slot, n, e, 0, 0, 0);
  endtask

  // Build a star-shaped polygon around a random center; squares give axis-aligned edges.
  task automatic build_polygon(int sides);
    real ang, scale;
    poly_sides = sides;
    span = ($urandom_range(0, 9) == 0) ? $urandom_range(100000, 3000000)
                                       : $urandom_range(500, 60000);
    center_n = $urandom_range(0, 2 * (8000000 - span)) - (8000000 - span);
    center_e = $urandom_range(0, 2 * (8000000 - span)) - (8000000 - span);
    if (sides == 4 && $urandom_range(0, 1)) begin
      load_vertex(0, center_n - span, center_e - span);
      load_vertex(1, center_n + span, center_e - span);
      load_vertex(2, center_n + span, center_e + span);
      load_vertex(3, center_n - span, center_e + span);
    end else begin
      for (int k = 0; k < sides; k++) begin
        ang = 6.283185307 * k / sides;
        scale = 0.5 + 0.5 * $urandom_range(0, 1000) / 1000.0;
        load_vertex(k, center_n + $rtoi(span * scale * $cos(ang)),
                    center_e + $rtoi(span * scale * $sin(ang)));
      end
    end
  endtask

  task automatic load_obstacle(int slot);
    int r, h;
    r = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8388607) : $urandom_range(0, span / 4);
    h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388607) : $urandom_range(0, 5000);
    send_op(pzc_pkg::OP_LOAD_OBSTACLE, slot, center_n + $urandom_range(0, span) - span / 2,
            center_e + $urandom_range(0, span) - span / 2, 0, r, h);
  endtask

  // Random query: mostly inside the zone's box, some on vertices, edge midpoints or anywhere.
  task automatic random_check();
    int n, e, d, r, k, j, roll;
    roll = $urandom_range(0, 99);
    k = $urandom_range(0, poly_sides - 1);
    j = (k + 1 == poly_sides) ? 0 : k + 1;
    if (roll < 65) begin
      n = center_n + $urandom_range(0, 2 * span) - span;
      e = center_e + $urandom_range(0, 2 * span) - span;
    end else if (roll < 75) begin
      n = poly_north[k];
      e = poly_east[k];
    end else if (roll < 88) begin
      n = (poly_north[k] + poly_north[j]) / 2 + $urandom_range(0, 2) - 1;
      e = (poly_east[k] + poly_east[j]) / 2 + $urandom_range(0, 2) - 1;
    end else begin
      n = $urandom;
      e = $urandom;
    end
    roll = $urandom_range(0, 99);
    if (roll < 25) r = 0;
    else if (roll < 90) r = $urandom_range(0, span / 6 + 1);
    else r = $urandom_range(0, 8388607);
    d = $urandom_range(0, 1) ? $urandom : -$urandom_range(0, 6000);
    send_op(pzc_pkg::OP_CHECK, 0, n, e, d, r, $urandom);
  endtask

  initial begin
    int sent, sides, bval, cval, roll;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: a square at the coordinate extremes, with one cylinder at the origin.
    write_cfg(pzc_pkg::CFG_BOUNDARY_COUNT, 5'd4);
    write_cfg(pzc_pkg::CFG_CYLINDER_COUNT, 5'd1);
    cfg_write <= 1'b0;
    span = 8388607;
    center_n = 0;
    center_e = 0;
    poly_sides = 4;
    load_vertex(0, -8388608, -8388608);
    load_vertex(1, -8388608, 8388607);
    load_vertex(2, 8388607, 8388607);
    load_vertex(3, 8388607, -8388608);
    for (int s = 0; s < pzc_pkg::MAX_OBSTACLES; s++)
      send_op(pzc_pkg::OP_LOAD_OBSTACLE, s, 0, 0, 0, 100, 1000);
    send_op(pzc_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0);                 // inside a cylinder
    send_op(pzc_pkg::OP_CHECK, 0, 0, 0, -8388608, 0, 0);          // high above the cylinder
    send_op(pzc_pkg::OP_CHECK, 0, 4000, 4000, 0, 0, 0);           // clear
    send_op(pzc_pkg::OP_CHECK, 0, 8388607, 0, 0, 0, 0);           // on a horizontal edge
    send_op(pzc_pkg::OP_CHECK, 0, 0, -8388608, 0, 0, 0);          // on a vertical edge
    send_op(pzc_pkg::OP_CHECK, 0, -8388608, -8388608, 0, 0, 0);   // on a corner
    send_op(pzc_pkg::OP_CHECK, 0, 0, 0, 0, 8388607, 0);           // largest clearance: too near
    send_op(pzc_pkg::OP_CHECK, 0, 8000000, 8000000, 8388607, 500000, 8388607);
    send_op(OP_UNUSED, 15, -1, -1, -1, 8388607, 8388607);         // unknown op, ignored
    drain();

    // Directed: degenerate edge (two equal vertices) and a point outside a small triangle.
    write_cfg(pzc_pkg::CFG_BOUNDARY_COUNT, 5'd0);                 // saturates to three
    write_cfg(pzc_pkg::CFG_CYLINDER_COUNT, 5'd31);                // saturates to sixteen
    write_cfg(CFG_SPARE_LOW, 5'd7);                               // index beyond the list
    write_cfg(CFG_SPARE_HIGH, 5'd31);
    cfg_write <= 1'b0;
    load_vertex(0, 0, 0);
    load_vertex(1, 0, 0);
    load_vertex(2, 1000, 1000);
    send_op(pzc_pkg::OP_CHECK, 0, 5000, 5000, 0, 0, 0);
    send_op(pzc_pkg::OP_CHECK, 0, 0, 10, 0, 20, 0);
    send_op(pzc_pkg::OP_CHECK, 0, 500, 500, 0, 0, 0);
    drain();

    // Random phases: each one rewrites the config, rebuilds the zone, then runs queries.
    sent = 0;
    while (sent < 1850) begin
      roll = $urandom_range(0, 9);
      bval = (roll < 2) ? ((roll == 0) ? 3 : 16) : ((roll == 2) ? $urandom_range(0, 31)
                                                               : $urandom_range(3, 16));
      cval = (roll < 2) ? ((roll == 0) ? 0 : 16) : $urandom_range(0, 31);
      write_cfg(pzc_pkg::CFG_BOUNDARY_COUNT, bval[pzc_pkg::COUNT_BITS-1:0]);
      write_cfg(pzc_pkg::CFG_CYLINDER_COUNT, cval[pzc_pkg::COUNT_BITS-1:0]);
      cfg_write <= 1'b0;
      sides = (bval < 3) ? 3 : (bval > 16) ? 16 : bval;
      quiet = ($urandom_range(0, 4) == 0);
      build_polygon(sides);
      for (int s = 0; s < pzc_pkg::MAX_OBSTACLES; s++) load_obstacle(s);
      sent += sides + pzc_pkg::MAX_OBSTACLES;
      for (int q = 0; q < 70; q++) begin
        roll = $urandom_range(0, 99);
        if (roll < 90) random_check();
        else if (roll < 95) load_obstacle($urandom_range(0, pzc_pkg::MAX_OBSTACLES - 1));
        else send_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (roll < 95) sent++;
      end
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
